/* rtl/ogs_pkg.sv */
// ----------------------------------------------------------------------------
// ogs_pkg
// Shared constants, types and helpers of the glyph segmenter.
// ----------------------------------------------------------------------------
package ogs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int GLYPH_SIZE  = 8;
    localparam int DIM_W       = 9;
    localparam int COORD_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int CELL_W      = 3;
    localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
    localparam int STEP_W      = 12;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic                  found;
        logic [COORD_W-1:0]    line_top;
        logic [COORD_W-1:0]    line_bottom;
        logic [COORD_W-1:0]    char_left;
        logic [COORD_W-1:0]    char_right;
        logic [DIM_W-1:0]      char_number;
        logic [GLYPH_BITS-1:0] glyph;
    } ogs_result_t;

    typedef struct packed {
        logic [3:0]       quot;
        logic [DIM_W-1:0] rem;
    } ogs_step_t;

    // Advances a cell index by one pixel: adds the glyph size to the
    // remainder and divides by the box size with a short restoring division.
    function automatic ogs_step_t ogs_cell_step(logic [DIM_W-1:0] rem,
                                                logic [DIM_W-1:0] size);
        logic [STEP_W-1:0] v;
        logic [STEP_W-1:0] d;
        logic [3:0]        q;
        ogs_step_t         s;
        v = STEP_W'(rem) + STEP_W'(GLYPH_SIZE);
        q = '0;
        for (int b = 3; b >= 0; b--)
        begin
            d = STEP_W'(size) << b;
            if (v >= d)
            begin
                v    = v - d;
                q[b] = 1'b1;
            end
        end
        s.quot = q;
        s.rem  = v[DIM_W-1:0];
        return s;
    endfunction

endpackage

/* rtl/ogs_pixel_ram.sv */
// ----------------------------------------------------------------------------
// ogs_pixel_ram
// One-bit pixel store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ogs_pixel_ram (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ogs_pkg::ADDR_W-1:0] wr_addr,
    input  logic                      wr_bit,
    input  logic [ogs_pkg::ADDR_W-1:0] rd_addr,
    output logic                      rd_bit
);
    import ogs_pkg::*;

    logic mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_bit <= mem[rd_addr];
    end

endmodule

/* rtl/ogs_scanner.sv */
// ----------------------------------------------------------------------------
// ogs_scanner
// Row, column and glyph walk over the pixel store for one fetch.
// ----------------------------------------------------------------------------
module ogs_scanner (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ogs_pkg::DIM_W-1:0]   width,
    input  logic [ogs_pkg::DIM_W-1:0]   height,
    output logic                        busy,
    output logic [ogs_pkg::ADDR_W-1:0]  rd_addr,
    input  logic                        rd_bit,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ogs_pkg::ogs_result_t        res
);
    import ogs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROW_START, S_ROW_RD, S_ROW_CHK, S_COL_START,
        S_COL_RD, S_COL_CHK, S_GLY_RD, S_GLY_CHK, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_ROWS, PH_COLS, PH_DONE
    } phase_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [DIM_W-1:0]   scan_row_reg, scan_row_next;
    logic [DIM_W-1:0]   scan_col_reg, scan_col_next;
    logic               row_ink_reg, row_ink_next;
    logic               col_ink_reg, col_ink_next;
    logic [COORD_W-1:0] top_reg, top_next;
    logic [COORD_W-1:0] left_reg, left_next;
    logic [COORD_W-1:0] right_reg, right_next;
    logic [DIM_W-1:0]   count_reg, count_next;
    logic [DIM_W-1:0]   cur_x_reg, cur_x_next;
    logic [DIM_W-1:0]   cur_y_reg, cur_y_next;
    logic [CELL_W-1:0]  cx_reg, cx_next;
    logic [CELL_W-1:0]  cy_reg, cy_next;
    logic [DIM_W-1:0]   remx_reg, remx_next;
    logic [DIM_W-1:0]   remy_reg, remy_next;
    logic [GLYPH_BITS-1:0] glyph_reg, glyph_next;
    ogs_result_t        res_reg, res_next;

    logic [DIM_W-1:0]   bottom;
    logic [DIM_W-1:0]   box_w;
    logic [DIM_W-1:0]   box_h;
    logic [COORD_W-1:0] addr_x;
    logic [COORD_W-1:0] addr_y;
    logic [ADDR_W:0]    addr_full;
    logic [GLYPH_BITS-1:0] glyph_hit;
    ogs_step_t          step_x;
    ogs_step_t          step_y;
    ogs_result_t        res_none;

    assign bottom   = (scan_row_reg >= DIM_W'(2)) ? scan_row_reg - DIM_W'(2) : '0;
    assign box_w    = DIM_W'(right_reg) - DIM_W'(left_reg);
    assign box_h    = bottom - DIM_W'(top_reg);
    assign step_x   = ogs_cell_step(remx_reg, box_w);
    assign step_y   = ogs_cell_step(remy_reg, box_h);
    assign res_none = '0;

    always_comb
    begin
        case (state_reg)
            S_ROW_RD:
            begin
                addr_x = cur_x_reg[COORD_W-1:0];
                addr_y = scan_row_reg[COORD_W-1:0];
            end
            S_COL_RD:
            begin
                addr_x = scan_col_reg[COORD_W-1:0];
                addr_y = cur_y_reg[COORD_W-1:0];
            end
            default:
            begin
                addr_x = cur_x_reg[COORD_W-1:0];
                addr_y = cur_y_reg[COORD_W-1:0];
            end
        endcase
        addr_full = (ADDR_W+1)'(addr_y * width) + (ADDR_W+1)'(addr_x);
    end

    assign rd_addr   = addr_full[ADDR_W-1:0];
    assign glyph_hit = glyph_reg | (GLYPH_BITS'(rd_bit) << {cy_reg, cx_reg});

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        row_ink_next  = row_ink_reg;
        col_ink_next  = col_ink_reg;
        top_next      = top_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        count_next    = count_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        remx_next     = remx_reg;
        remy_next     = remy_reg;
        glyph_next    = glyph_reg;
        res_next      = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (phase_reg)
                        PH_ROWS:
                        begin
                            state_next = S_ROW_START;
                        end
                        PH_COLS:
                        begin
                            state_next = S_COL_START;
                        end
                        default:
                        begin
                            res_next   = res_none;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_ROW_START:
            begin
                if (scan_row_reg >= height)
                begin
                    phase_next = PH_DONE;
                    res_next   = res_none;
                    state_next = S_EMIT;
                end
                else
                begin
                    cur_x_next = '0;
                    state_next = S_ROW_RD;
                end
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_CHK;
            end
            S_ROW_CHK:
            begin
                if (!rd_bit && (cur_x_reg + DIM_W'(1) < width))
                begin
                    cur_x_next = cur_x_reg + DIM_W'(1);
                    state_next = S_ROW_RD;
                end
                else
                begin
                    scan_row_next = scan_row_reg + DIM_W'(1);
                    if (rd_bit && !row_ink_reg)
                    begin
                        top_next = scan_row_reg[COORD_W-1:0];
                    end
                    if (!rd_bit && row_ink_reg)
                    begin
                        row_ink_next  = 1'b0;
                        phase_next    = PH_COLS;
                        scan_col_next = '0;
                        col_ink_next  = 1'b0;
                        count_next    = '0;
                        state_next    = S_COL_START;
                    end
                    else
                    begin
                        row_ink_next = rd_bit;
                        state_next   = S_ROW_START;
                    end
                end
            end
            S_COL_START:
            begin
                if ((scan_col_reg >= width) || (DIM_W'(top_reg) >= bottom))
                begin
                    phase_next = PH_ROWS;
                    state_next = S_ROW_START;
                end
                else
                begin
                    cur_y_next = DIM_W'(top_reg);
                    state_next = S_COL_RD;
                end
            end
            S_COL_RD:
            begin
                state_next = S_COL_CHK;
            end
            S_COL_CHK:
            begin
                if (!rd_bit && (cur_y_reg + DIM_W'(1) < bottom))
                begin
                    cur_y_next = cur_y_reg + DIM_W'(1);
                    state_next = S_COL_RD;
                end
                else
                begin
                    scan_col_next = scan_col_reg + DIM_W'(1);
                    if (rd_bit && !col_ink_reg)
                    begin
                        left_next = scan_col_reg[COORD_W-1:0];
                    end
                    if (!rd_bit && col_ink_reg)
                    begin
                        col_ink_next = 1'b0;
                        count_next   = count_reg + DIM_W'(1);
                        right_next   = scan_col_reg[COORD_W-1:0];
                        cur_x_next   = DIM_W'(left_reg);
                        cur_y_next   = DIM_W'(top_reg);
                        cx_next      = '0;
                        cy_next      = '0;
                        remx_next    = '0;
                        remy_next    = '0;
                        glyph_next   = '0;
                        state_next   = S_GLY_RD;
                    end
                    else
                    begin
                        col_ink_next = rd_bit;
                        state_next   = S_COL_START;
                    end
                end
            end
            S_GLY_RD:
            begin
                state_next = S_GLY_CHK;
            end
            S_GLY_CHK:
            begin
                glyph_next = glyph_hit;
                if (cur_x_reg + DIM_W'(1) >= DIM_W'(right_reg))
                begin
                    cur_x_next = DIM_W'(left_reg);
                    cx_next    = '0;
                    remx_next  = '0;
                    if (cur_y_reg + DIM_W'(1) >= bottom)
                    begin
                        res_next.found       = 1'b1;
                        res_next.line_top    = top_reg;
                        res_next.line_bottom = bottom[COORD_W-1:0];
                        res_next.char_left   = left_reg;
                        res_next.char_right  = right_reg;
                        res_next.char_number = count_reg;
                        res_next.glyph       = glyph_hit;
                        state_next           = S_EMIT;
                    end
                    else
                    begin
                        cur_y_next = cur_y_reg + DIM_W'(1);
                        cy_next    = CELL_W'(4'(cy_reg) + step_y.quot);
                        remy_next  = step_y.rem;
                        state_next = S_GLY_RD;
                    end
                end
                else
                begin
                    cur_x_next = cur_x_reg + DIM_W'(1);
                    cx_next    = CELL_W'(4'(cx_reg) + step_x.quot);
                    remx_next  = step_x.rem;
                    state_next = S_GLY_RD;
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            phase_reg    <= PH_ROWS;
            scan_row_reg <= '0;
            scan_col_reg <= '0;
            row_ink_reg  <= 1'b0;
            col_ink_reg  <= 1'b0;
            top_reg      <= '0;
            left_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            scan_row_reg <= scan_row_next;
            scan_col_reg <= scan_col_next;
            row_ink_reg  <= row_ink_next;
            col_ink_reg  <= col_ink_next;
            top_reg      <= top_next;
            left_reg     <= left_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        right_reg <= right_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        remx_reg  <= remx_next;
        remy_reg  <= remy_next;
        glyph_reg <= glyph_next;
        res_reg   <= res_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule

/* rtl/ocr_glyph_segmenter_core.sv */
// ----------------------------------------------------------------------------
// ocr_glyph_segmenter_core
// Stores a binary image and returns segmented characters with 8x8 glyphs.
//
//   channel | direction | handshake             | payload
//   in      | in        | in_valid / in_stall   | operation, pixel_rgb
//   out     | out       | out_valid / out_stall | found ... glyph
//   cfg     | in        | cfg_we                | cfg_index, cfg_wdata
//
// A load writes one pixel. A fetch reads through the single read port of
// the pixel store, with a read and a check state for every pixel (rows up
// to their first black pixel, columns up to theirs, then the whole character
// box), a start state for each row and column walked, and an emit state.
// Reset clears the scan state; the pixel store is undefined until loaded.
// The input stalls while a fetch is in progress and a finished result waits.
// ----------------------------------------------------------------------------
module ocr_glyph_segmenter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [23:0]                       pixel_rgb,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [ogs_pkg::COORD_W-1:0]       line_top,
    output logic [ogs_pkg::COORD_W-1:0]       line_bottom,
    output logic [ogs_pkg::COORD_W-1:0]       char_left,
    output logic [ogs_pkg::COORD_W-1:0]       char_right,
    output logic [ogs_pkg::DIM_W-1:0]         char_number,
    output logic [ogs_pkg::GLYPH_BITS-1:0]    glyph,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [ogs_pkg::DIM_W-1:0]         cfg_wdata
);
    import ogs_pkg::*;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [ADDR_W-1:0] load_pos_reg;
    logic              out_valid_reg;
    ogs_result_t       out_reg;

    logic              accept;
    logic              load_en;
    logic              fetch_go;
    logic              scan_busy;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_bit;
    logic              res_valid;
    logic              res_ready;
    ogs_result_t       res;

    function automatic logic [DIM_W-1:0] clamp_size(logic [DIM_W-1:0] v,
                                                    logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > max_v)
        begin
            r = max_v;
        end
        return r;
    endfunction

    assign in_stall  = scan_busy;
    assign accept    = in_valid && !in_stall;
    assign load_en   = accept && (operation == OP_LOAD);
    assign fetch_go  = accept && (operation == OP_FETCH);
    assign res_ready = !out_valid_reg || !out_stall;

    ogs_pixel_ram u_ram (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (load_pos_reg),
        .wr_bit  (pixel_rgb == 24'd0),
        .rd_addr (rd_addr),
        .rd_bit  (rd_bit)
    );

    ogs_scanner u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (fetch_go),
        .width     (width_reg),
        .height    (height_reg),
        .busy      (scan_busy),
        .rd_addr   (rd_addr),
        .rd_bit    (rd_bit),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_W'(MAX_WIDTH);
            height_reg    <= DIM_W'(MAX_HEIGHT);
            load_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                begin
                    width_reg <= clamp_size(cfg_wdata, DIM_W'(MAX_WIDTH));
                end
                else
                begin
                    height_reg <= clamp_size(cfg_wdata, DIM_W'(MAX_HEIGHT));
                end
            end
            if (load_en)
            begin
                load_pos_reg <= load_pos_reg + ADDR_W'(1);
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_reg.found;
    assign line_top    = out_reg.line_top;
    assign line_bottom = out_reg.line_bottom;
    assign char_left   = out_reg.char_left;
    assign char_right  = out_reg.char_right;
    assign char_number = out_reg.char_number;
    assign glyph       = out_reg.glyph;

    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_go |=> scan_busy)
        else $error("fetch beat did not start the scan");

    a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |=> (load_pos_reg == $past(load_pos_reg) + ADDR_W'(1)))
        else $error("load position did not advance");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (glyph == '0 && char_number == '0))
        else $error("exhausted result carries data");

    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        (width_reg != '0) && (width_reg <= DIM_W'(MAX_WIDTH))
        && (height_reg != '0) && (height_reg <= DIM_W'(MAX_HEIGHT)))
        else $error("image size out of range");

endmodule

/* dv/ogs_result_checker.sv */
// ----------------------------------------------------------------------------
// ogs_result_checker
// Watches the input, output and register ports of the glyph segmenter. It
// keeps its own copy of the stored image and of the scan position, works out
// the character record that each accepted fetch beat must return, and
// compares every accepted output beat with the oldest expected record.
// ----------------------------------------------------------------------------
module ogs_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           operation,
    input  logic [23:0]                    pixel_rgb,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           found,
    input  logic [ogs_pkg::COORD_W-1:0]    line_top,
    input  logic [ogs_pkg::COORD_W-1:0]    line_bottom,
    input  logic [ogs_pkg::COORD_W-1:0]    char_left,
    input  logic [ogs_pkg::COORD_W-1:0]    char_right,
    input  logic [ogs_pkg::DIM_W-1:0]      char_number,
    input  logic [ogs_pkg::GLYPH_BITS-1:0] glyph,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [ogs_pkg::DIM_W-1:0]      cfg_wdata,
    output int                             mismatches,
    output int                             outstanding
);
    import ogs_pkg::*;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef enum logic [1:0] {SCAN_ROWS, SCAN_COLS, SCAN_DONE} scan_phase_t;

    bit          ink [STORE_DEPTH];
    int unsigned load_addr;
    int unsigned row_pos;
    int unsigned col_pos;
    bit          prev_row_ink;
    bit          prev_col_ink;
    int unsigned open_top;
    int unsigned open_left;
    int unsigned char_count;
    int unsigned cols_in_use;
    int unsigned rows_in_use;
    scan_phase_t phase;

    ogs_result_t char_records [$];

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    function automatic bit black_at(int unsigned x, int unsigned y);
        int unsigned addr;
        addr = y * cols_in_use + x;
        if (addr >= STORE_DEPTH)
            return 1'b0;
        return ink[addr];
    endfunction

    function automatic bit row_has_ink(int unsigned y);
        for (int unsigned x = 0; x < cols_in_use; x++)
            if (black_at(x, y))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit column_has_ink(int unsigned x, int unsigned t, int unsigned b);
        for (int unsigned y = t; y < b; y++)
            if (black_at(x, y))
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [GLYPH_BITS-1:0] glyph_of(int unsigned l, int unsigned r,
                                                       int unsigned t, int unsigned b);
        logic [GLYPH_BITS-1:0] g;
        int unsigned           cx;
        int unsigned           cy;
        g = '0;
        if (r == l || b == t)
            return g;
        for (int unsigned y = t; y < b; y++)
        begin
            cy = (GLYPH_SIZE * (y - t)) / (b - t);
            for (int unsigned x = l; x < r; x++)
            begin
                cx = (GLYPH_SIZE * (x - l)) / (r - l);
                if (black_at(x, y) && cx < GLYPH_SIZE && cy < GLYPH_SIZE)
                    g[cy * GLYPH_SIZE + cx] = 1'b1;
            end
        end
        return g;
    endfunction

    function automatic ogs_result_t next_character();
        ogs_result_t rec;
        int unsigned y;
        int unsigned x;
        int unsigned bot;
        bit          cur;
        rec = '0;
        forever
        begin
            if (phase == SCAN_ROWS)
            begin
                while (row_pos < rows_in_use)
                begin
                    y = row_pos;
                    cur = row_has_ink(y);
                    row_pos++;
                    if (cur && !prev_row_ink)
                        open_top = y;
                    if (!cur && prev_row_ink)
                    begin
                        prev_row_ink = 1'b0;
                        phase = SCAN_COLS;
                        col_pos = 0;
                        prev_col_ink = 1'b0;
                        char_count = 0;
                        break;
                    end
                    prev_row_ink = cur;
                end
                if (phase == SCAN_ROWS)
                begin
                    phase = SCAN_DONE;
                    return rec;
                end
            end
            else if (phase == SCAN_COLS)
            begin
                bot = (row_pos >= 2) ? row_pos - 2 : 0;
                while (col_pos < cols_in_use)
                begin
                    x = col_pos;
                    cur = (open_top < bot) ? column_has_ink(x, open_top, bot) : 1'b0;
                    col_pos++;
                    if (cur && !prev_col_ink)
                        open_left = x;
                    if (!cur && prev_col_ink)
                    begin
                        prev_col_ink = 1'b0;
                        char_count = (char_count + 1) & 9'h1FF;
                        rec.found       = 1'b1;
                        rec.line_top    = open_top[COORD_W-1:0];
                        rec.line_bottom = bot[COORD_W-1:0];
                        rec.char_left   = open_left[COORD_W-1:0];
                        rec.char_right  = x[COORD_W-1:0];
                        rec.char_number = char_count[DIM_W-1:0];
                        rec.glyph       = glyph_of(open_left, x, open_top, bot);
                        return rec;
                    end
                    prev_col_ink = cur;
                end
                phase = SCAN_ROWS;
            end
            else
            begin
                return rec;
            end
        end
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_addr    = 0;
            row_pos      = 0;
            col_pos      = 0;
            prev_row_ink = 1'b0;
            prev_col_ink = 1'b0;
            open_top     = 0;
            open_left    = 0;
            char_count   = 0;
            cols_in_use  = MAX_WIDTH;
            rows_in_use  = MAX_HEIGHT;
            phase        = SCAN_ROWS;
            mismatches   = 0;
            char_records.delete();
            outstanding  = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    cols_in_use = clamp_dim(cfg_wdata, MAX_WIDTH);
                else
                    rows_in_use = clamp_dim(cfg_wdata, MAX_HEIGHT);
            end
            if (in_valid && !in_stall)
            begin
                if (operation == OP_LOAD)
                begin
                    ink[load_addr] = (pixel_rgb == 24'h0);
                    load_addr = (load_addr + 1) % STORE_DEPTH;
                end
                else
                begin
                    char_records.push_back(next_character());
                end
            end
            if (out_valid && !out_stall)
            begin
                if (char_records.size() == 0)
                begin
                    report("unexpected beat", 64'(found), 64'h0);
                end
                else
                begin
                    ogs_result_t want;
                    want = char_records.pop_front();
                    if (found !== want.found)
                        report("found", 64'(found), 64'(want.found));
                    if (line_top !== want.line_top)
                        report("line_top", 64'(line_top), 64'(want.line_top));
                    if (line_bottom !== want.line_bottom)
                        report("line_bottom", 64'(line_bottom), 64'(want.line_bottom));
                    if (char_left !== want.char_left)
                        report("char_left", 64'(char_left), 64'(want.char_left));
                    if (char_right !== want.char_right)
                        report("char_right", 64'(char_right), 64'(want.char_right));
                    if (char_number !== want.char_number)
                        report("char_number", 64'(char_number), 64'(want.char_number));
                    if (glyph !== want.glyph)
                        report("glyph", glyph, want.glyph);
                end
            end
            outstanding = char_records.size();
        end
    end

endmodule

/* dv/tb_ocr_glyph_segmenter_core.sv */
// ----------------------------------------------------------------------------
// tb_ocr_glyph_segmenter_core
// Builds images out of text lines with known character runs, loads them
// pixel by pixel, grows the image height between phases and fetches exactly
// the characters that the loaded lines hold, then runs the scan out and
// writes the register extremes. A checker module predicts every record.
// ----------------------------------------------------------------------------
module tb_ocr_glyph_segmenter_core;
    import ogs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = OP_LOAD;
    logic [23:0]           pixel_rgb = 24'h0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [COORD_W-1:0]    line_top;
    logic [COORD_W-1:0]    line_bottom;
    logic [COORD_W-1:0]    char_left;
    logic [COORD_W-1:0]    char_right;
    logic [DIM_W-1:0]      char_number;
    logic [GLYPH_BITS-1:0] glyph;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]      cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    int          beats_sent = 0;
    int          send_idle_pct = 31;
    int          recv_stall_pct = 67;
    int unsigned cols;
    int unsigned rows_loaded = 0;
    int unsigned chars_ready = 0;
    int unsigned chars_fetched = 0;

    ocr_glyph_segmenter_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_rgb(pixel_rgb),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .line_top(line_top), .line_bottom(line_bottom),
        .char_left(char_left), .char_right(char_right),
        .char_number(char_number), .glyph(glyph),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    ogs_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .pixel_rgb(pixel_rgb),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .line_top(line_top), .line_bottom(line_bottom),
        .char_left(char_left), .char_right(char_right),
        .char_number(char_number), .glyph(glyph),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(logic op, logic [23:0] rgb);
        if (beats_sent < 300)
        begin
            send_idle_pct  = 31;
            recv_stall_pct = 67;
        end
        else if (beats_sent < 650)
        begin
            send_idle_pct  = 67;
            recv_stall_pct = 31;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        pixel_rgb = rgb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic load_pixel(bit black);
        logic [23:0] rgb;
        case ($urandom_range(0, 7))
            0: rgb = 24'hFFFFFF;
            1: rgb = 24'h1 << $urandom_range(0, 23);
            default: rgb = 24'($urandom_range(1, 24'hFFFFFF));
        endcase
        send_beat(OP_LOAD, black ? 24'h0 : rgb);
    endtask

    // A text line of the given height: its top row is black exactly on the
    // character columns (a one-row line also on random others), inner rows are
    // black on a random, never empty, part of them and the last row, outside
    // the projected range, is random. Then come gap blank rows.
    task automatic put_line(int unsigned height, logic [255:0] char_cols, int unsigned gap);
        int unsigned mark;
        bit          black;
        bit          row_ink;
        for (int unsigned r = 0; r < height; r++)
        begin
            mark = $urandom_range(0, cols - 1);
            row_ink = 1'b0;
            for (int unsigned x = 0; x < cols; x++)
            begin
                if (height == 1)
                    black = char_cols[x] || ($urandom_range(0, 3) == 0);
                else if (r == 0)
                    black = char_cols[x];
                else if (r == height - 1)
                    black = ($urandom_range(0, 2) == 0) || x == mark;
                else
                    black = char_cols[x] && (!row_ink || $urandom_range(0, 1));
                row_ink = row_ink || black;
                load_pixel(black);
            end
        end
        repeat (gap)
            for (int unsigned x = 0; x < cols; x++)
                load_pixel(1'b0);
        rows_loaded += height + gap;
        if (height >= 2)
            for (int unsigned x = 1; x < cols; x++)
                if (char_cols[x-1] && !char_cols[x])
                    chars_ready++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic fetch_ready();
        drain();
        write_reg(REG_IMAGE_HEIGHT, DIM_W'(rows_loaded));
        while (chars_fetched < chars_ready)
        begin
            send_beat(OP_FETCH, 24'($urandom()));
            chars_fetched++;
        end
    endtask

    initial
    begin
        logic [255:0] char_cols;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        cols = $urandom_range(9, 16);
        write_reg(REG_IMAGE_WIDTH, DIM_W'(cols));

        put_line(1, 256'h4, 1);
        put_line(2, 256'h1, 2);
        put_line(4, (256'h1 << (cols - 1)) | 256'h36, 1);
        put_line(3, (256'h1 << cols) - 1, 1);
        put_line(5, 256'h1 << (cols - 2), 2);
        fetch_ready();

        while ((beats_sent < 700 || chars_fetched < 48) && rows_loaded < 200)
        begin
            repeat ($urandom_range(1, 3))
            begin
                char_cols = '0;
                for (int unsigned x = 0; x < cols; x++)
                    char_cols[x] = ($urandom_range(0, 9) < 6);
                if (char_cols == 0)
                    char_cols[$urandom_range(0, cols - 1)] = 1'b1;
                put_line(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 9), char_cols,
                         $urandom_range(1, 2));
            end
            fetch_ready();
        end

        // A line still open at the bottom, then the exhausted scan.
        put_line(3, 256'h3, 0);
        fetch_ready();
        repeat (3)
            send_beat(OP_FETCH, 24'h0);
        drain();
        write_reg(REG_IMAGE_WIDTH, 9'h1FF);
        write_reg(REG_IMAGE_HEIGHT, 9'h000);
        send_beat(OP_FETCH, 24'hFFFFFF);
        drain();
        write_reg(REG_IMAGE_WIDTH, 9'h000);
        write_reg(REG_IMAGE_HEIGHT, 9'h1FF);
        send_beat(OP_FETCH, 24'h0);
        drain();
        repeat (20)
            @(negedge clk);

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/ogs_pkg.sv
rtl/ogs_pixel_ram.sv
rtl/ogs_scanner.sv
rtl/ocr_glyph_segmenter_core.sv
dv/ogs_result_checker.sv
dv/tb_ocr_glyph_segmenter_core.sv
